/* rtl/core/uee_pkg.sv */
// ----------------------------------------------------------------------------
// uee_pkg
// Shared constants and controller/datapath interface types for the unique
// edge extractor.
// ----------------------------------------------------------------------------
package uee_pkg;

   // Sizing
   localparam int MAX_EDGES      = 1024;
   localparam int MAX_POLY_VERTS = 16;
   localparam int VERTEX_BITS    = 16;

   localparam int EDGE_IDX_BITS  = $clog2(MAX_EDGES);
   localparam int EDGE_CNT_BITS  = $clog2(MAX_EDGES + 1);
   localparam int POLY_IDX_BITS  = $clog2(MAX_POLY_VERTS);
   localparam int POLY_CNT_BITS  = $clog2(MAX_POLY_VERTS + 1);

   // Input command codes
   localparam logic CMD_VERTEX = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // Result kind codes
   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic take_clear;    // clear transaction accepted
      logic take_vertex;   // vertex transaction accepted
      logic load_prev;     // fetch closing vertex of the loop
      logic load_cur;      // fetch current vertex, restart search
      logic search;        // step the table scan
      logic insert;        // append edge (or flag overflow)
      logic advance;       // move to next edge of the loop
      logic summary;       // emit summary, drop polygon
   } uee_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;           // stored edge matches
      logic miss;          // scan finished without a match
      logic last_edge;     // current edge closes the loop
   } uee_status_type;

endpackage

/* rtl/core/uee_ctrl.sv */
// ----------------------------------------------------------------------------
// uee_ctrl
// Sequencer: accepts transactions, walks the polygon loop edge by edge and
// steps the datapath through fetch, table scan, insert and summary.
// ----------------------------------------------------------------------------
module uee_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_command,
   input  logic                   req_last_in_polygon,
   input  uee_pkg::uee_status_type status,
   output uee_pkg::uee_cmd_type    cmd,
   output logic                   busy
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_PREP    = 6'b000010,
      ST_LOAD    = 6'b000100,
      ST_SEARCH  = 6'b001000,
      ST_INSERT  = 6'b010000,
      ST_SUMMARY = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == uee_pkg::CMD_CLEAR) begin
                  cmd.take_clear = 1'b1;
               end else begin
                  cmd.take_vertex = 1'b1;
                  if (req_last_in_polygon) begin
                     state_in = ST_PREP;
                  end
               end
            end
         end
         ST_PREP: begin
            cmd.load_prev = 1'b1;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_cur = 1'b1;
            state_in     = ST_SEARCH;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.hit) begin
               cmd.advance = 1'b1;
               state_in    = status.last_edge ? ST_SUMMARY : ST_LOAD;
            end else if (status.miss) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert  = 1'b1;
            cmd.advance = 1'b1;
            state_in    = status.last_edge ? ST_SUMMARY : ST_LOAD;
         end
         ST_SUMMARY: begin
            cmd.summary = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/uee_datapath.sv */
// ----------------------------------------------------------------------------
// uee_datapath
// Polygon buffer, edge table memory with linear scan, counters, sticky
// overflow flag and the registered result port.
// ----------------------------------------------------------------------------
module uee_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  uee_pkg::uee_cmd_type                    cmd,
   input  logic [uee_pkg::VERTEX_BITS-1:0]        req_vertex_index,
   output uee_pkg::uee_status_type                 status,
   output logic                                   rsp_strobe,
   output logic                                   rsp_result_kind,
   output logic [uee_pkg::VERTEX_BITS-1:0]        rsp_end_a,
   output logic [uee_pkg::VERTEX_BITS-1:0]        rsp_end_b,
   output logic [uee_pkg::EDGE_IDX_BITS-1:0]      rsp_edge_slot,
   output logic [uee_pkg::EDGE_CNT_BITS-1:0]      rsp_edge_total,
   output logic                                   rsp_overflow,
   output logic                                   rsp_last_result
);

   localparam int VB = uee_pkg::VERTEX_BITS;
   localparam int EI = uee_pkg::EDGE_IDX_BITS;
   localparam int EC = uee_pkg::EDGE_CNT_BITS;
   localparam int PI = uee_pkg::POLY_IDX_BITS;
   localparam int PC = uee_pkg::POLY_CNT_BITS;

   // Storage
   logic [VB-1:0]   poly_ff [uee_pkg::MAX_POLY_VERTS];
   logic [2*VB-1:0] edge_mem_ff [uee_pkg::MAX_EDGES];

   // Control registers
   logic [PC-1:0] len_ff, len_in;
   logic [PI-1:0] k_ff, k_in;
   logic [EC-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [EC-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_pend_ff, rd_pend_in;

   // Payload registers
   logic [VB-1:0]   prev_ff, prev_in;
   logic [VB-1:0]   cur_ff, cur_in;
   logic [2*VB-1:0] rd_data_ff;

   // Result registers
   logic          strobe_ff, strobe_in;
   logic          kind_ff, kind_in;
   logic [VB-1:0] end_a_ff, end_a_in;
   logic [VB-1:0] end_b_ff, end_b_in;
   logic [EI-1:0] slot_ff, slot_in;
   logic [EC-1:0] total_ff, total_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic          last_ff, last_in;

   logic          poly_room;
   logic          table_room;
   logic          issue;
   logic          match;
   logic [PI-1:0] tail_idx;
   logic [VB-1:0] stored_a;
   logic [VB-1:0] stored_b;

   assign poly_room  = (len_ff < PC'(uee_pkg::MAX_POLY_VERTS));
   assign table_room = (count_ff < EC'(uee_pkg::MAX_EDGES));
   assign tail_idx   = PI'(len_ff - PC'(1));
   assign stored_a   = rd_data_ff[2*VB-1:VB];
   assign stored_b   = rd_data_ff[VB-1:0];

   // Undirected compare against the entry read last cycle
   assign match = ((prev_ff == stored_a) && (cur_ff == stored_b)) ||
                  ((prev_ff == stored_b) && (cur_ff == stored_a));

   assign issue            = cmd.search && (rd_idx_ff < count_ff);
   assign status.hit       = rd_pend_ff && match;
   assign status.miss      = !rd_pend_ff && (rd_idx_ff == count_ff);
   assign status.last_edge = ((PC'(k_ff) + PC'(1)) == len_ff);

   // Next-state logic
   always_comb begin
      len_in     = len_ff;
      k_in       = k_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      rd_idx_in  = rd_idx_ff;
      rd_pend_in = 1'b0;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      strobe_in  = 1'b0;
      kind_in    = kind_ff;
      end_a_in   = end_a_ff;
      end_b_in   = end_b_ff;
      slot_in    = slot_ff;
      total_in   = total_ff;
      rsp_ovf_in = rsp_ovf_ff;
      last_in    = last_ff;

      if (cmd.take_clear) begin
         count_in   = '0;
         len_in     = '0;
         ovf_in     = 1'b0;
         strobe_in  = 1'b1;
         kind_in    = uee_pkg::KIND_SUMMARY;
         end_a_in   = '0;
         end_b_in   = '0;
         slot_in    = '0;
         total_in   = '0;
         rsp_ovf_in = 1'b0;
         last_in    = 1'b1;
      end

      if (cmd.take_vertex) begin
         if (poly_room) begin
            len_in = len_ff + PC'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      // Loop starts with the edge from the last vertex to the first
      if (cmd.load_prev) begin
         prev_in = poly_ff[tail_idx];
         k_in    = '0;
      end

      if (cmd.load_cur) begin
         cur_in    = poly_ff[k_ff];
         rd_idx_in = '0;
      end

      // Table scan, one entry per cycle
      if (issue) begin
         rd_idx_in  = rd_idx_ff + EC'(1);
         rd_pend_in = 1'b1;
      end

      if (cmd.insert) begin
         if (table_room) begin
            count_in   = count_ff + EC'(1);
            strobe_in  = 1'b1;
            kind_in    = uee_pkg::KIND_EDGE;
            end_a_in   = prev_ff;
            end_b_in   = cur_ff;
            slot_in    = count_ff[EI-1:0];
            total_in   = count_ff + EC'(1);
            rsp_ovf_in = ovf_ff;
            last_in    = 1'b0;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.advance) begin
         prev_in = cur_ff;
         k_in    = k_ff + PI'(1);
      end

      if (cmd.summary) begin
         len_in     = '0;
         strobe_in  = 1'b1;
         kind_in    = uee_pkg::KIND_SUMMARY;
         end_a_in   = '0;
         end_b_in   = '0;
         slot_in    = '0;
         total_in   = count_ff;
         rsp_ovf_in = ovf_ff;
         last_in    = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         k_ff       <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         rd_idx_ff  <= '0;
         rd_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         len_ff     <= len_in;
         k_ff       <= k_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         rd_idx_ff  <= rd_idx_in;
         rd_pend_ff <= rd_pend_in;
         strobe_ff  <= strobe_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      kind_ff    <= kind_in;
      end_a_ff   <= end_a_in;
      end_b_ff   <= end_b_in;
      slot_ff    <= slot_in;
      total_ff   <= total_in;
      rsp_ovf_ff <= rsp_ovf_in;
      last_ff    <= last_in;
   end

   // Polygon buffer
   always_ff @(posedge clock) begin
      if (cmd.take_vertex && poly_room) begin
         poly_ff[len_ff[PI-1:0]] <= req_vertex_index;
      end
   end

   // Edge table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.insert && table_room) begin
         edge_mem_ff[count_ff[EI-1:0]] <= {prev_ff, cur_ff};
      end
      rd_data_ff <= edge_mem_ff[rd_idx_ff[EI-1:0]];
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_end_a       = end_a_ff;
   assign rsp_end_b       = end_b_ff;
   assign rsp_edge_slot   = slot_ff;
   assign rsp_edge_total  = total_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_result = last_ff;

endmodule

/* rtl/core/unique_edge_extractor_top.sv */
// A clear shows its summary in the cycle after acceptance; a vertex that does
// not close a polygon gives no result and is taken every cycle while idle.
// A closing vertex runs each loop edge as fetch, scan and, on a miss, insert;
// the scan walks the stored edges through the single read port of the edge
// table, and the summary follows the last edge.
// Reset empties the edge table and polygon buffer at once; no clearing pass.
// ----------------------------------------------------------------------------
// unique_edge_extractor_top
// Collects polygon vertices and appends each new undirected loop edge to a
// table, reporting new edges and a per-polygon or clear summary.
// ----------------------------------------------------------------------------
module unique_edge_extractor_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_command,
   input  logic [uee_pkg::VERTEX_BITS-1:0]        req_vertex_index,
   input  logic                                   req_last_in_polygon,
   output logic                                   rsp_strobe,
   output logic                                   rsp_result_kind,
   output logic [uee_pkg::VERTEX_BITS-1:0]        rsp_end_a,
   output logic [uee_pkg::VERTEX_BITS-1:0]        rsp_end_b,
   output logic [uee_pkg::EDGE_IDX_BITS-1:0]      rsp_edge_slot,
   output logic [uee_pkg::EDGE_CNT_BITS-1:0]      rsp_edge_total,
   output logic                                   rsp_overflow,
   output logic                                   rsp_last_result
);

   uee_pkg::uee_cmd_type    cmd;
   uee_pkg::uee_status_type status;

   // Sequencer
   uee_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_command         (req_command),
      .req_last_in_polygon (req_last_in_polygon),
      .status              (status),
      .cmd                 (cmd),
      .busy                (busy)
   );

   // Storage and result path
   uee_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_vertex_index (req_vertex_index),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_end_a        (rsp_end_a),
      .rsp_end_b        (rsp_end_b),
      .rsp_edge_slot    (rsp_edge_slot),
      .rsp_edge_total   (rsp_edge_total),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

/* tb/sv/tb_unique_edge_extractor_top.sv */
// ----------------------------------------------------------------------------
// tb_unique_edge_extractor_top
// Self-checking bench for the unique edge extractor. A tracker class keeps
// its own copy of the edge table and polygon buffer and predicts the edge
// and summary reports of every accepted transaction. Each strobed report
// is checked field by field against the oldest prediction. Stimulus runs
// in two parts. A directed part covers extreme indices, degenerate and
// oversized polygons, and clears. A random part sends polygons of random
// length, most of them drawn from a small vertex pool so that edges repeat.
// ----------------------------------------------------------------------------
module tb_unique_edge_extractor_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT      = 10_000_000;
   localparam int RANDOM_ITEMS     = 80;
   localparam int TABLE_CAP_RANDOM = 150;   // keeps scans short in the random part
   localparam int POOL_SIZE        = 8;

   typedef logic [uee_pkg::VERTEX_BITS-1:0] vertex_type;

   typedef struct packed {
      logic                              kind;
      vertex_type                        end_a;
      vertex_type                        end_b;
      logic [uee_pkg::EDGE_IDX_BITS-1:0] slot;
      logic [uee_pkg::EDGE_CNT_BITS-1:0] total;
      logic                              overflow;
      logic                              last;
   } edge_report_type;

   // Tracks the edge table and predicts the reports of each transaction
   class edge_table_tracker;
      vertex_type      first_end  [uee_pkg::MAX_EDGES];
      vertex_type      second_end [uee_pkg::MAX_EDGES];
      vertex_type      poly       [uee_pkg::MAX_POLY_VERTS];
      int unsigned     edge_cnt;
      int unsigned     poly_len;
      logic            overflow_seen;
      edge_report_type expected_reports[$];
      int unsigned     errors;

      function new();
         edge_cnt      = 0;
         poly_len      = 0;
         overflow_seen = 1'b0;
         errors        = 0;
      endfunction

      // Undirected lookup: either orientation matches
      function bit stored(vertex_type a, vertex_type b);
         for (int i = 0; i < edge_cnt; i++) begin
            if ((first_end[i] == a && second_end[i] == b) ||
                (first_end[i] == b && second_end[i] == a))
               return 1'b1;
         end
         return 1'b0;
      endfunction

      function void queue_report(logic kind, vertex_type a, vertex_type b,
                                 int unsigned slot, logic last);
         edge_report_type r;
         r.kind     = kind;
         r.end_a    = a;
         r.end_b    = b;
         r.slot     = uee_pkg::EDGE_IDX_BITS'(slot);
         r.total    = uee_pkg::EDGE_CNT_BITS'(edge_cnt);
         r.overflow = overflow_seen;
         r.last     = last;
         expected_reports.push_back(r);
      endfunction

      function void take_input(logic cmd, vertex_type vtx, logic lst);
         vertex_type  prev;
         int unsigned slot;
         if (cmd == uee_pkg::CMD_CLEAR) begin
            edge_cnt      = 0;
            poly_len      = 0;
            overflow_seen = 1'b0;
            queue_report(uee_pkg::KIND_SUMMARY, '0, '0, 0, 1'b1);
            return;
         end
         // buffer full: vertex dropped, even a closing one
         if (poly_len < uee_pkg::MAX_POLY_VERTS) begin
            poly[poly_len] = vtx;
            poly_len++;
         end else begin
            overflow_seen = 1'b1;
         end
         if (!lst)
            return;
         // closed loop: last to first, then consecutive pairs
         prev = poly[poly_len - 1];
         for (int k = 0; k < poly_len; k++) begin
            if (!stored(prev, poly[k])) begin
               if (edge_cnt < uee_pkg::MAX_EDGES) begin
                  slot             = edge_cnt;
                  first_end[slot]  = prev;
                  second_end[slot] = poly[k];
                  edge_cnt++;
                  queue_report(uee_pkg::KIND_EDGE, prev, poly[k], slot, 1'b0);
               end else begin
                  overflow_seen = 1'b1;
               end
            end
            prev = poly[k];
         end
         poly_len = 0;
         queue_report(uee_pkg::KIND_SUMMARY, '0, '0, 0, 1'b1);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_report(edge_report_type got);
         edge_report_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: report with nothing expected: kind %0d a %0d b %0d total %0d",
                     $time, got.kind, got.end_a, got.end_b, got.total);
            errors++;
            return;
         end
         want = expected_reports.pop_front();
         compare("result_kind", 32'(want.kind),     32'(got.kind));
         compare("end_a",       32'(want.end_a),    32'(got.end_a));
         compare("end_b",       32'(want.end_b),    32'(got.end_b));
         compare("edge_slot",   32'(want.slot),     32'(got.slot));
         compare("edge_total",  32'(want.total),    32'(got.total));
         compare("overflow",    32'(want.overflow), 32'(got.overflow));
         compare("last_result", 32'(want.last),     32'(got.last));
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_command;
   vertex_type                        req_vertex_index;
   logic                              req_last_in_polygon;
   logic                              rsp_strobe;
   logic                              rsp_result_kind;
   vertex_type                        rsp_end_a;
   vertex_type                        rsp_end_b;
   logic [uee_pkg::EDGE_IDX_BITS-1:0] rsp_edge_slot;
   logic [uee_pkg::EDGE_CNT_BITS-1:0] rsp_edge_total;
   logic                              rsp_overflow;
   logic                              rsp_last_result;

   edge_table_tracker tracker = new();
   int unsigned       cycle_count = 0;
   int unsigned       burst_left = 0;

   unique_edge_extractor_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_vertex_index    (req_vertex_index),
      .req_last_in_polygon (req_last_in_polygon),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_end_a           (rsp_end_a),
      .rsp_end_b           (rsp_end_b),
      .rsp_edge_slot       (rsp_edge_slot),
      .rsp_edge_total      (rsp_edge_total),
      .rsp_overflow        (rsp_overflow),
      .rsp_last_result     (rsp_last_result)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Report monitor: one report per strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         tracker.check_report({rsp_result_kind, rsp_end_a, rsp_end_b, rsp_edge_slot,
                               rsp_edge_total, rsp_overflow, rsp_last_result});
   end

   // One transaction; idles between most bursts, holds start until busy is low
   task automatic send_item(input logic cmd, input vertex_type vtx, input logic lst);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start               <= 1'b1;
      req_command         <= cmd;
      req_vertex_index    <= vtx;
      req_last_in_polygon <= lst;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.take_input(cmd, vtx, lst);
   endtask

   task automatic send_polygon(input vertex_type verts[$]);
      foreach (verts[i])
         send_item(uee_pkg::CMD_VERTEX, verts[i], i == verts.size() - 1);
   endtask

   initial begin
      vertex_type  shape[$];
      vertex_type  pool[POOL_SIZE];
      int unsigned rand_sent;
      int unsigned len;
      bit          from_pool;

      reset               <= 1'b1;
      start               <= 1'b0;
      req_command         <= uee_pkg::CMD_VERTEX;
      req_vertex_index    <= '0;
      req_last_in_polygon <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: clear with last flag set, then degenerate and extreme polygons
      send_item(uee_pkg::CMD_CLEAR, '1, 1'b1);
      shape = '{16'h0000};                       // self-edge
      send_polygon(shape);
      shape = '{16'hFFFF, 16'h0000};             // one edge, reverse matches
      send_polygon(shape);
      shape = '{16'h5555, 16'hAAAA, 16'h0000};
      send_polygon(shape);
      shape = '{16'h0000, 16'hAAAA, 16'h5555};   // all edges already stored
      send_polygon(shape);
      shape = {};
      for (int i = 0; i <= uee_pkg::MAX_POLY_VERTS; i++)  // one vertex too many
         shape.push_back(vertex_type'(16'h0100 + i));
      send_polygon(shape);
      send_item(uee_pkg::CMD_CLEAR, '0, 1'b0);

      // Random polygons, mostly from a small pool so edges recur
      for (int p = 0; p < POOL_SIZE; p++)
         pool[p] = vertex_type'($urandom);
      rand_sent = 0;
      while (rand_sent < RANDOM_ITEMS) begin
         if (tracker.edge_cnt > TABLE_CAP_RANDOM || $urandom_range(0, 9) == 0) begin
            send_item(uee_pkg::CMD_CLEAR, vertex_type'($urandom), 1'($urandom));
            rand_sent++;
         end else begin
            len = ($urandom_range(0, 7) == 0) ?
                  $urandom_range(uee_pkg::MAX_POLY_VERTS + 1, uee_pkg::MAX_POLY_VERTS + 4) :
                  $urandom_range(1, uee_pkg::MAX_POLY_VERTS);
            from_pool = $urandom_range(0, 4) < 3;
            if ($urandom_range(0, 5) == 0)
               pool[$urandom_range(0, POOL_SIZE - 1)] = vertex_type'($urandom);
            for (int j = 0; j < len; j++) begin
               // clear in the middle of a polygon drops it
               if (j < len - 1 && $urandom_range(0, 24) == 0) begin
                  send_item(uee_pkg::CMD_CLEAR, vertex_type'($urandom), 1'($urandom));
                  rand_sent++;
                  break;
               end
               send_item(uee_pkg::CMD_VERTEX,
                         from_pool ? pool[$urandom_range(0, POOL_SIZE - 1)] :
                                     vertex_type'($urandom),
                         j == len - 1);
               rand_sent++;
            end
         end
      end
      send_item(uee_pkg::CMD_CLEAR, '1, 1'b0);

      // Drain
      start <= 1'b0;
      while (tracker.expected_reports.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (tracker.errors == 0 && tracker.expected_reports.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
